// ===== hdl/median_selector_assert.svh =====
// assertion macros shared by the checker files
// each macro expects signals named clk and rst in the scope of use
`ifndef MEDIAN_SELECTOR_ASSERT_SVH
`define MEDIAN_SELECTOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define MS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// condition that must hold on the cycle after reset is applied
`define MS_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/medsel_pkg.sv =====
// ----------------------------------------------------------------------------
// medsel_pkg
// Shared types for the median selector: controller states and the command
// and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package medsel_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_MID,
    ST_MID_LO,
    ST_MID_HI,
    ST_EMIT
  } state_t;

  // read address selection
  typedef enum logic [1:0] {
    RD_PREV,
    RD_LO,
    RD_HI
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load;      // capture the incoming request
    logic    rd_en;     // issue a store read
    rd_sel_t rd_sel;    // which address to read
    logic    shift;     // move the entry below up one place
    logic    place;     // write the new value and bump the count
    logic    drop;      // store full, mark overflow
    logic    latch_lo;  // keep lower middle element
    logic    sum_en;    // register the middle sum
    logic    emit;      // load the result register and clear the set
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic greater;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/medsel_ctrl.sv =====
// ----------------------------------------------------------------------------
// medsel_ctrl
// Sequencer for insertion and median read-out: walks the store from the top
// down shifting larger entries, then reads the two middle entries.
// ----------------------------------------------------------------------------
`default_nettype none

module medsel_ctrl
  import medsel_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_PREV;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status.full) begin
          cmd.drop   = 1'b1;
          state_next = status.last ? ST_MID : ST_IDLE;
        end else if (status.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = status.last ? ST_MID : ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.greater) begin
          cmd.shift  = 1'b1;
          state_next = ST_CHECK;
        end else begin
          cmd.place  = 1'b1;
          state_next = status.last ? ST_MID : ST_IDLE;
        end
      end
      ST_MID: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LO;
        state_next = ST_MID_LO;
      end
      ST_MID_LO: begin
        cmd.latch_lo = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_HI;
        state_next   = ST_MID_HI;
      end
      ST_MID_HI: begin
        cmd.sum_en = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/medsel_dp.sv =====
// ----------------------------------------------------------------------------
// medsel_dp
// Datapath: sorted store memory, element count, overflow flag, insertion
// pointer, middle sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module medsel_dp
  import medsel_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [DATA_W-1:0]   in_value,
  input  wire logic                in_last,
  input  wire cmd_t                cmd,
  output status_t                  status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DATA_W-1:0]        out_median,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_overflow
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  // sorted store
  logic [DATA_W-1:0] store [MAX_ITEMS];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  // set state and working registers
  logic [CW-1:0]     held;
  logic              dropped;
  logic [CW-1:0]     pos;
  logic [DATA_W-1:0] val;
  logic              last;
  logic [DATA_W-1:0] lo;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   sum_adj;
  logic [CW-1:0]     prev_full;
  logic [CW-1:0]     lo_full;
  logic [CW-1:0]     hi_full;

  // address arithmetic
  assign prev_full = pos - CW'(1);
  assign lo_full   = (held - CW'(1)) >> 1;
  assign hi_full   = held >> 1;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_addr = prev_full[AW-1:0];
      RD_LO:   rd_addr = lo_full[AW-1:0];
      RD_HI:   rd_addr = hi_full[AW-1:0];
      default: rd_addr = prev_full[AW-1:0];
    endcase
  end

  assign wr_en   = cmd.shift | cmd.place;
  assign wr_addr = pos[AW-1:0];
  assign wr_data = cmd.place ? val : rd_data;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.emit) begin
        held    <= '0;
        dropped <= 1'b0;
      end else begin
        if (cmd.place) begin
          held <= held + CW'(1);
        end
        if (cmd.drop) begin
          dropped <= 1'b1;
        end
      end
    end
  end

  // request capture and insertion pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val  <= in_value;
      last <= in_last;
      pos  <= held;
    end else if (cmd.shift) begin
      pos <= prev_full;
    end
  end

  // middle elements and their sum
  always_ff @(posedge clk) begin
    if (cmd.latch_lo) begin
      lo <= rd_data;
    end
    if (cmd.sum_en) begin
      sum <= {lo[DATA_W-1], lo} + {rd_data[DATA_W-1], rd_data};
    end
  end

  // halve, truncating toward zero
  assign sum_adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_median   <= sum_adj[DATA_W:1];
      out_count    <= COUNT_W'(held);
      out_overflow <= dropped;
    end
  end

  // status to controller
  assign status.full     = (held == CW'(MAX_ITEMS));
  assign status.pos_zero = (pos == '0);
  assign status.greater  = ($signed(rd_data) > $signed(val));
  assign status.last     = last;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== hdl/median_selector.sv =====
// ----------------------------------------------------------------------------
// median_selector
// Streaming median of signed 32-bit integers with a sorted element store.
// ----------------------------------------------------------------------------
// Elements arrive one per request on the slave stream, tlast marking the
// final element of a set. Each element is inserted into a sorted store of
// MAX_ITEMS entries held in a single-port-read memory: the sequencer walks
// down from the top, moving each larger entry up one place, with one memory
// read and then one compare and write for each entry moved. The next request
// is taken once the element is placed, or after the result is emitted for the
// last element of a set; an element arriving on a full store is dropped and
// flags overflow. After the last element the two middle entries are read in
// turn and averaged, and the result enters the output register once that
// register is free, waiting while the previous result still waits there.
// One result per set:
// median (even counts averaged, truncated toward zero), count of kept
// elements (low 7 bits) and the overflow flag. The store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module median_selector
  import medsel_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic        s_axis_tlast,
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] median, [38:32] count, [39] zero
  output logic [0:0]       m_axis_tuser    // [0] overflow
);

  cmd_t                cmd;
  status_t             status;
  logic [DATA_W-1:0]   median;
  logic [COUNT_W-1:0]  count;
  logic                overflow;

  // sequencer
  medsel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // store and arithmetic
  medsel_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_value     (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_median   (median),
    .out_count    (count),
    .out_overflow (overflow)
  );

  // result packing
  assign m_axis_tdata = {1'b0, count, median};
  assign m_axis_tuser = overflow;

endmodule

`default_nettype wire

// ===== hdl/medsel_port_checker.sv =====
// ----------------------------------------------------------------------------
// medsel_port_checker
// Port-level checks on the median selector, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_selector_assert.svh"

module medsel_port_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  localparam logic [6:0] FULL_COUNT = 7'(MAX_ITEMS);

  // no result straight after reset
  `MS_ASSERT_RESET(a_reset_quiet, !m_axis_tvalid)

  // a stalled result holds
  `MS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // each accepted request closes the input in the cycle after it
  `MS_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // overflow only once the store has been filled
  `MS_ASSERT_IMPL(a_ovf_full, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[38:32] == FULL_COUNT)

  // a set always keeps at least one element
  `MS_ASSERT_IMPL(a_count_nonzero, m_axis_tvalid && (MAX_ITEMS < 128), m_axis_tdata[38:32] != 7'd0)

endmodule

bind median_selector medsel_port_checker #(.MAX_ITEMS(MAX_ITEMS)) u_port_checker (.*);

`default_nettype wire
